[rtl/mutual_exclusion_node_macros.svh]
// ----------------------------------------------------------------------------
// mutual_exclusion_node assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MUTUAL_EXCLUSION_NODE_MACROS_SVH
`define MUTUAL_EXCLUSION_NODE_MACROS_SVH

// same-cycle implication, off during reset
`define MXN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MXN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mxn_pkg.sv]
// ----------------------------------------------------------------------------
// mxn_pkg
// Types, codes and helpers shared by the mutual exclusion node.
// ----------------------------------------------------------------------------
package mxn_pkg;

    localparam int MAX_NODES = 16;
    localparam int ID_W      = 5;
    localparam int SEC_W     = 32;
    localparam int NSEC_W    = 30;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int QDEPTH    = 2;   // power of two
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // register indexes of the write port
    localparam logic [0:0] REG_OWN_ID     = 1'b0;
    localparam logic [0:0] REG_NODE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_WANT    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_REPLY   = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_NOTHING   = 3'd0,
        ACT_BROADCAST = 3'd1,
        ACT_REPLY     = 3'd2,
        ACT_ENTERED   = 3'd3,
        ACT_RELEASED  = 3'd4,
        ACT_ERROR     = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PENDING = 2'd1,
        MODE_EXEC    = 2'd2
    } mode_t;

    // configuration as seen by the front and back
    typedef struct packed {
        logic [ID_W-1:0]      own_id;
        logic [CNT_W-1:0]     nodes;
        logic [MAX_NODES-1:0] others;
    } ctx_t;

    // classified word held in the queue
    typedef struct packed {
        op_t                  kind;
        logic [ID_W-1:0]      peer_id;
        logic                 peer_ok;
        logic [MAX_NODES-1:0] peer_bit;
        logic [SEC_W-1:0]     sec;
        logic [NSEC_W-1:0]    nsec;
    } cmd_t;

    function automatic logic [CNT_W-1:0] nodes_in_use(input logic [ID_W-1:0] node_count);
        logic [CNT_W-1:0] n;
        if (int'(node_count) > MAX_NODES) begin
            n = CNT_W'(MAX_NODES);
        end else begin
            n = CNT_W'(node_count);
        end
        return n;
    endfunction

    function automatic logic [MAX_NODES-1:0] others_mask(input logic [CNT_W-1:0] nodes,
                                                        input logic [ID_W-1:0]  own_id);
        logic [MAX_NODES-1:0] m;
        for (int i = 0; i < MAX_NODES; i++) begin
            m[i] = (i < int'(nodes)) && ((i + 1) != int'(own_id));
        end
        return m;
    endfunction

endpackage

[rtl/mxn_front.sv]
// ----------------------------------------------------------------------------
// mxn_front
// Accepts input words, checks the peer id and queues classified commands.
// ----------------------------------------------------------------------------
module mxn_front import mxn_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctx_t               ctx,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_op,
    input  logic [ID_W-1:0]    in_peer,
    input  logic [SEC_W-1:0]   in_sec,
    input  logic [NSEC_W-1:0]  in_nsec,
    output logic               q_valid,
    output cmd_t               q_cmd,
    input  logic               q_pop
);

    cmd_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    cmd_t              cmd_in;
    logic              push;
    logic              pop;

    always_comb begin
        cmd_in.kind    = op_t'(in_op);
        cmd_in.peer_id = in_peer;
        cmd_in.peer_ok = (in_peer != '0) && (int'(in_peer) <= int'(ctx.nodes))
                         && (in_peer != ctx.own_id);
        for (int i = 0; i < MAX_NODES; i++) begin
            cmd_in.peer_bit[i] = (int'(in_peer) == i + 1);
        end
        cmd_in.sec  = in_sec;
        cmd_in.nsec = in_nsec;
    end

    assign in_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = q_mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

[rtl/mxn_back.sv]
// ----------------------------------------------------------------------------
// mxn_back
// Executes queued commands against the node state and drives the result word.
// ----------------------------------------------------------------------------
module mxn_back import mxn_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctx_t               ctx,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    output mode_t              mode,
    output logic               out_valid,
    input  logic               out_ready,
    output action_t            out_action,
    output logic [ID_W-1:0]    out_dest,
    output logic [SEC_W-1:0]   out_sec,
    output logic [NSEC_W-1:0]  out_nsec,
    output logic               out_last
);

    typedef enum logic [1:0] {
        S_RUN,
        S_ENTER,
        S_RELEASE
    } state_t;

    state_t               state_reg,    state_next;
    mode_t                mode_reg,     mode_next;
    logic [MAX_NODES-1:0] deferred_reg, deferred_next;
    logic [MAX_NODES-1:0] replied_reg,  replied_next;
    logic [MAX_NODES-1:0] pend_reg,     pend_next;
    logic [SEC_W-1:0]     own_sec_reg,  own_sec_next;
    logic [NSEC_W-1:0]    own_nsec_reg, own_nsec_next;
    logic                 valid_reg,    valid_next;
    action_t              action_reg,   action_next;
    logic [ID_W-1:0]      dest_reg,     dest_next;
    logic [SEC_W-1:0]     sec_reg,      sec_next;
    logic [NSEC_W-1:0]    nsec_reg,     nsec_next;
    logic                 last_reg,     last_next;

    logic                 slot_free;
    logic                 reply_now;
    logic [IDX_W-1:0]     low_idx;
    logic [MAX_NODES-1:0] replied_new;

    assign slot_free = !valid_reg || out_ready;

    // request arbitration: earlier stamp wins, lower id on a tie
    always_comb begin
        case (mode_reg)
            MODE_IDLE: reply_now = 1'b1;
            MODE_EXEC: reply_now = 1'b0;
            default: begin
                if (q_cmd.sec != own_sec_reg) begin
                    reply_now = q_cmd.sec < own_sec_reg;
                end else if (q_cmd.nsec != own_nsec_reg) begin
                    reply_now = q_cmd.nsec < own_nsec_reg;
                end else begin
                    reply_now = q_cmd.peer_id < ctx.own_id;
                end
            end
        endcase
    end

    // lowest deferred peer still owed a reply
    always_comb begin
        low_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                low_idx = IDX_W'(i);
            end
        end
    end

    assign replied_new = replied_reg | q_cmd.peer_bit;

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        deferred_next = deferred_reg;
        replied_next  = replied_reg;
        pend_next     = pend_reg;
        own_sec_next  = own_sec_reg;
        own_nsec_next = own_nsec_reg;
        valid_next    = valid_reg && !out_ready;
        action_next   = action_reg;
        dest_next     = dest_reg;
        sec_next      = sec_reg;
        nsec_next     = nsec_reg;
        last_next     = last_reg;
        q_pop         = 1'b0;

        case (state_reg)
            S_RUN: begin
                if (q_valid && slot_free) begin
                    q_pop       = 1'b1;
                    valid_next  = 1'b1;
                    action_next = ACT_NOTHING;
                    dest_next   = '0;
                    sec_next    = '0;
                    nsec_next   = '0;
                    last_next   = 1'b1;
                    case (q_cmd.kind)
                        OP_WANT: begin
                            if (mode_reg != MODE_IDLE) begin
                                action_next = ACT_ERROR;
                            end else begin
                                mode_next     = MODE_PENDING;
                                replied_next  = '0;
                                own_sec_next  = q_cmd.sec;
                                own_nsec_next = q_cmd.nsec;
                                action_next   = ACT_BROADCAST;
                                sec_next      = q_cmd.sec;
                                nsec_next     = q_cmd.nsec;
                                if (ctx.others == '0) begin
                                    last_next  = 1'b0;
                                    state_next = S_ENTER;
                                end
                            end
                        end
                        OP_REQUEST: begin
                            if (!q_cmd.peer_ok) begin
                                action_next = ACT_ERROR;
                            end else if (reply_now) begin
                                action_next = ACT_REPLY;
                                dest_next   = q_cmd.peer_id;
                                if (mode_reg == MODE_IDLE) begin
                                    deferred_next = deferred_reg & ~q_cmd.peer_bit;
                                end
                            end else begin
                                deferred_next = deferred_reg | q_cmd.peer_bit;
                            end
                        end
                        OP_REPLY: begin
                            if (!q_cmd.peer_ok) begin
                                action_next = ACT_ERROR;
                            end else if (mode_reg == MODE_PENDING) begin
                                replied_next = replied_new;
                                if ((replied_new & ctx.others) == ctx.others) begin
                                    mode_next   = MODE_EXEC;
                                    action_next = ACT_ENTERED;
                                end
                            end
                        end
                        OP_RELEASE: begin
                            if (mode_reg != MODE_EXEC) begin
                                action_next = ACT_ERROR;
                            end else begin
                                // no word yet; the walk emits them
                                valid_next = valid_reg && !out_ready;
                                pend_next  = deferred_reg & ctx.others;
                                state_next = S_RELEASE;
                            end
                        end
                        default: begin
                            action_next = ACT_ERROR;
                        end
                    endcase
                end
            end
            S_ENTER: begin
                if (slot_free) begin
                    valid_next  = 1'b1;
                    action_next = ACT_ENTERED;
                    dest_next   = '0;
                    sec_next    = '0;
                    nsec_next   = '0;
                    last_next   = 1'b1;
                    mode_next   = MODE_EXEC;
                    state_next  = S_RUN;
                end
            end
            S_RELEASE: begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    sec_next   = '0;
                    nsec_next  = '0;
                    if (pend_reg != '0) begin
                        action_next = ACT_REPLY;
                        dest_next   = ID_W'(int'(low_idx) + 1);
                        last_next   = 1'b0;
                        pend_next   = pend_reg & (pend_reg - 1'b1);
                    end else begin
                        action_next   = ACT_RELEASED;
                        dest_next     = '0;
                        last_next     = 1'b1;
                        deferred_next = '0;
                        mode_next     = MODE_IDLE;
                        state_next    = S_RUN;
                    end
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_RUN;
            mode_reg     <= MODE_IDLE;
            deferred_reg <= '0;
            replied_reg  <= '0;
            pend_reg     <= '0;
            own_sec_reg  <= '0;
            own_nsec_reg <= '0;
            valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            deferred_reg <= deferred_next;
            replied_reg  <= replied_next;
            pend_reg     <= pend_next;
            own_sec_reg  <= own_sec_next;
            own_nsec_reg <= own_nsec_next;
            valid_reg    <= valid_next;
        end
        action_reg <= action_next;
        dest_reg   <= dest_next;
        sec_reg    <= sec_next;
        nsec_reg   <= nsec_next;
        last_reg   <= last_next;
    end

    assign mode       = mode_reg;
    assign out_valid  = valid_reg;
    assign out_action = action_reg;
    assign out_dest   = dest_reg;
    assign out_sec    = sec_reg;
    assign out_nsec   = nsec_reg;
    assign out_last   = last_reg;

endmodule

[rtl/mutual_exclusion_node.sv]
// ----------------------------------------------------------------------------
// mutual_exclusion_node
// One node of distributed mutual exclusion with timestamped requests.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-----------------------------------
//  s_        | in  | s_tvalid/s_tready  | tuser: operation; tdata: peer, stamp
//  m_        | out | m_tvalid/m_tready  | tuser: action; tdata: dest, stamp;
//            |     |                    | tlast: final word of an input
//  cfg_      | in  | cfg_wr_en          | cfg_addr, cfg_wdata
//
//  Flow: an accepted word is registered in the queue, then executed into the
//  output register; a release pops with no word, then the reply walk in the
//  back end emits one word per deferred peer, one word per cycle while m_tready
//  holds, then "released"; a single-node want adds an "entered" word.
//  Reset: aresetn synchronous, active low; clears mode, bit sets, queue and
//  output valid; own_id returns to 1 and node_count to 16.
//  Stalls: a two-word queue decouples s_ from the back end; the output
//  register holds a word until m_tready, and the back end waits on it.
// ----------------------------------------------------------------------------
`include "mutual_exclusion_node_macros.svh"

module mutual_exclusion_node import mxn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // peer_id[4:0], stamp_sec[36:5], stamp_nsec[66:37], zero
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // dest_id[4:0], out_stamp_sec[36:5], out_stamp_nsec[66:37]
    output logic [2:0]  m_tuser,   // action[2:0]
    output logic        m_tlast,
    // configuration: 0 own_id, 1 node_count
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [4:0]  cfg_wdata
);

    logic [ID_W-1:0]   own_id_reg;
    logic [ID_W-1:0]   node_count_reg;
    ctx_t              ctx;

    logic              q_valid;
    cmd_t              q_cmd;
    logic              q_pop;
    mode_t             back_mode;

    action_t           out_action;
    logic [ID_W-1:0]   out_dest;
    logic [SEC_W-1:0]  out_sec;
    logic [NSEC_W-1:0] out_nsec;

    // configuration registers; the user must write them only while the node is quiet; the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg     <= ID_W'(1);
            node_count_reg <= ID_W'(16);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_OWN_ID:     own_id_reg     <= cfg_wdata;
                REG_NODE_COUNT: node_count_reg <= cfg_wdata;
                default:        own_id_reg     <= own_id_reg;
            endcase
        end
    end

    // node_count clamps to MAX_NODES; others excludes this node's own bit
    always_comb begin
        ctx.own_id = own_id_reg;
        ctx.nodes  = nodes_in_use(node_count_reg);
        ctx.others = others_mask(ctx.nodes, own_id_reg);
    end

    mxn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctx      (ctx),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_peer  (s_tdata[4:0]),
        .in_sec   (s_tdata[36:5]),
        .in_nsec  (s_tdata[66:37]),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    mxn_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctx        (ctx),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .mode       (back_mode),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_action (out_action),
        .out_dest   (out_dest),
        .out_sec    (out_sec),
        .out_nsec   (out_nsec),
        .out_last   (m_tlast)
    );

    assign m_tuser = out_action;
    assign m_tdata = {5'd0, out_nsec, out_sec, out_dest};

    // checks
    `MXN_ASSERT_IMP(a_entered_mode, aclk, aresetn, m_tvalid && m_tready && (m_tuser == ACT_ENTERED), back_mode == MODE_EXEC, "entered word taken while not executing")
    `MXN_ASSERT_IMP(a_reply_dest, aclk, aresetn, m_tvalid && (m_tuser == ACT_REPLY), m_tdata[4:0] != 5'd0, "reply without a destination")
    `MXN_ASSERT_IMP(a_stamp_zero, aclk, aresetn, m_tvalid && (m_tuser != ACT_BROADCAST), m_tdata[66:5] == 62'd0, "stamp on a non-broadcast word")
    `MXN_ASSERT_IMP(a_final_last, aclk, aresetn, m_tvalid && ((m_tuser == ACT_ERROR) || (m_tuser == ACT_RELEASED)), m_tlast, "error or released word not marked last")
    `MXN_ASSERT_NXT(a_pop_result, aclk, aresetn, q_pop && (q_cmd.kind != OP_RELEASE), m_tvalid, "executed command left no result word")

endmodule
